[rtl/core/rsti_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsti_pkg: shared types and constants of the radix string parser
// Character codes, register indexes, the symbol table layout and the
// types that travel between the parser and its alphabet decoder.
// ----------------------------------------------------------------------------
package rsti_pkg;

	localparam int CHAR_W     = 8;
	localparam int SYM_SLOTS  = 16;
	localparam int SYM_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = 5;
	localparam int OUT_W      = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	typedef logic [SYM_SLOTS-1:0][CHAR_W-1:0] sym_vec_t;

	typedef struct packed {
		logic                 hit;
		logic [SYM_IDX_W-1:0] idx;
	} digit_match_t;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             ok;
	} result_t;

	// Space, or one of the control characters tab through carriage return.
	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage
`default_nettype wire

[rtl/core/rsti_alphabet.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsti_alphabet: digit decoder and alphabet checker
// Maps a character to the index of the first matching symbol in use and
// judges whether the configured alphabet is usable.
// ----------------------------------------------------------------------------
module rsti_alphabet import rsti_pkg::*; #(
	parameter int MAX_SYMBOLS = 16
) (
	input  wire sym_vec_t          symbols,
	input  wire [CNT_W-1:0]        symbol_count,
	input  wire [CHAR_W-1:0]       char_in,
	output digit_match_t           digit,
	output logic                   alphabet_ok
);

	// Lowest matching index wins, so walk downward and let later hits override.
	always_comb begin
		digit = '0;
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < symbol_count) && (symbols[i] == char_in) &&
			    (char_in != CH_NUL)) begin
				digit.hit = 1'b1;
				digit.idx = SYM_IDX_W'(i);
			end
		end
	end

	always_comb begin
		logic bad;
		bad = (symbol_count < CNT_W'(2)) || (symbol_count > CNT_W'(MAX_SYMBOLS));
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (CNT_W'(i) < symbol_count) begin
				if ((symbols[i] == CH_MINUS) || (symbols[i] == CH_PLUS) ||
				    is_space(symbols[i]))
					bad = 1'b1;
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if ((CNT_W'(j) < symbol_count) && (symbols[j] == symbols[i]))
						bad = 1'b1;
				end
			end
		end
		alphabet_ok = !bad;
	end

endmodule
`default_nettype wire

[rtl/core/radix_string_to_int_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// radix_string_to_int_top: streaming string to integer parser
// Parses a zero-terminated character stream in a configurable digit
// alphabet and emits one signed result per string.
// ----------------------------------------------------------------------------
// The block takes one character per cycle, save while a zero byte waits for
// room in the result queue, and returns one result request for each zero
// byte it sees; other characters produce no result. Leading spaces and tab
// through carriage return are skipped, then a run of plus and minus signs is
// read (each minus flips the sign), then digits accumulate as value times
// symbol_count plus the digit's position in the alphabet until the first
// character that is not a digit; everything after that is ignored up to the
// zero byte. The alphabet lives in symbols_low (symbols 0 to 7) and
// symbols_high (symbols 8 to 15), one byte per symbol with the lowest symbol
// in the low byte, and symbol_count gives the radix. An alphabet with fewer
// than two symbols, more than MAX_SYMBOLS, a repeated symbol, or a sign or
// whitespace symbol is rejected: the result then carries alphabet_ok low
// and parsed_value zero. The magnitude wraps modulo 2^VALUE_BITS, is negated
// in that width, and parsed_value holds its low 32 bits (zero extended when
// VALUE_BITS is below 32). Throughput is one character per clock while the
// result queue has room, set by the single multiply-add and symbol compare
// that sit between the input register and the accumulator. A character is
// captured in an input register and folded into the parse state as it leaves
// that register; a zero byte leaves only when the result queue has room and
// then loads the output register, or the skid entry behind it while the
// output register is full, so characters keep flowing while a finished
// result waits for the consumer. Configuration should only be written while
// no string is in flight; the validity check is registered and settles
// after the configuration registers take a write.
module radix_string_to_int_top import rsti_pkg::*; #(
	parameter int MAX_SYMBOLS = 16,
	parameter int VALUE_BITS  = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [CHAR_W-1:0]      char_in,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic signed [OUT_W-1:0] parsed_value,
	output logic                   alphabet_ok
);

	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] symbols_low_q;
	logic [CFG_DATA_W-1:0] symbols_high_q;
	logic [CNT_W-1:0]      symbol_count_q;
	logic                  alphabet_ok_q;

	// Input register.
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	// Parse state.
	logic [1:0]            phase_q;
	logic                  negative_q;
	logic [VALUE_BITS-1:0] acc_q;

	// Output register and skid entry.
	result_t head_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	sym_vec_t     symbols;
	digit_match_t digit;
	logic         alpha_ok_now;

	assign symbols = {symbols_high_q, symbols_low_q};

	rsti_alphabet #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_alphabet (
		.symbols      (symbols),
		.symbol_count (symbol_count_q),
		.char_in      (char_s1),
		.digit        (digit),
		.alphabet_ok  (alpha_ok_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
			symbol_count_q <= '0;
			alphabet_ok_q  <= 1'b0;
		end else begin
			alphabet_ok_q <= alpha_ok_now;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data;
					CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_data;
					CFG_SYMBOL_COUNT: symbol_count_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Handshake control. A zero byte may only leave the input register when
	// the result queue has room; other characters never wait.
	logic is_term_s1;
	logic space;
	logic advance_s1;
	logic push;
	logic pop;

	assign is_term_s1 = (char_s1 == CH_NUL);
	assign space      = !skid_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!is_term_s1 || space);
	assign push       = advance_s1 && is_term_s1;
	assign pop        = out_valid_q && out_ready;
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	// Next parse state for the character in the input register.
	logic [1:0]            phase_d;
	logic                  negative_d;
	logic [VALUE_BITS-1:0] acc_d;
	logic [VALUE_BITS-1:0] acc_step;

	assign acc_step = VALUE_BITS'(acc_q * symbol_count_q) + VALUE_BITS'(digit.idx);

	always_comb begin
		logic in_sign;
		logic in_digit;
		phase_d    = phase_q;
		negative_d = negative_q;
		acc_d      = acc_q;
		in_sign    = 1'b0;
		in_digit   = 1'b0;
		if (is_term_s1) begin
			phase_d    = PH_SKIP;
			negative_d = 1'b0;
			acc_d      = '0;
		end else begin
			unique case (phase_q)
				PH_SKIP:  in_sign  = !is_space(char_s1);
				PH_SIGN:  in_sign  = 1'b1;
				PH_DIGIT: in_digit = 1'b1;
				PH_DONE:  ;
				default:  ;
			endcase
			if (in_sign) begin
				phase_d = PH_SIGN;
				if (char_s1 == CH_MINUS)
					negative_d = !negative_q;
				else if (char_s1 != CH_PLUS)
					in_digit = 1'b1;
			end
			if (in_digit) begin
				if (digit.hit) begin
					phase_d = PH_DIGIT;
					acc_d   = acc_step;
				end else begin
					phase_d = PH_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			negative_q <= 1'b0;
			acc_q      <= '0;
		end else if (advance_s1) begin
			phase_q    <= phase_d;
			negative_q <= negative_d;
			acc_q      <= acc_d;
		end
	end

	// Result of a finished string: signed magnitude in VALUE_BITS, then the
	// low 32 bits after zero extension.
	logic [VALUE_BITS-1:0]       signed_val;
	logic [VALUE_BITS+OUT_W-1:0] signed_ext;
	result_t                     new_res;

	assign signed_val = negative_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
	assign signed_ext = {{OUT_W{1'b0}}, signed_val};

	always_comb begin
		new_res.ok    = alphabet_ok_q;
		new_res.value = alphabet_ok_q ? signed_ext[OUT_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (!out_valid_q)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push)
					skid_q <= new_res;
			end else if (push) begin
				head_q <= new_res;
			end
		end else if (push) begin
			if (!out_valid_q)
				head_q <= new_res;
			else
				skid_q <= new_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = $signed(head_q.value);
	assign alphabet_ok  = head_q.ok;

endmodule
`default_nettype wire

[sim/rsti_result_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsti_result_checker: result predictor and comparator for the string parser
// Follows configuration writes and accepted characters, predicts one result
// per zero byte and checks every result request the parser hands out.
// ----------------------------------------------------------------------------
module rsti_result_checker import rsti_pkg::*; #(
	parameter int MAX_SYMBOLS = 16,
	parameter int VALUE_BITS  = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_wr_en,
	input  wire  [CFG_IDX_W-1:0]    cfg_index,
	input  wire  [CFG_DATA_W-1:0]   cfg_data,
	input  wire                     in_valid,
	input  wire                     in_ready,
	input  wire  [CHAR_W-1:0]       char_in,
	input  wire                     out_valid,
	input  wire                     out_ready,
	input  wire  signed [OUT_W-1:0] parsed_value,
	input  wire                     alphabet_ok,
	output int                      mismatches,
	output int                      pending,
	output int                      strings_checked,
	output int                      rejected_checked
);

	typedef enum logic [1:0] {
		PHASE_SKIP,
		PHASE_SIGN,
		PHASE_DIGITS,
		PHASE_DONE
	} parse_phase_t;

	logic [CFG_DATA_W-1:0] sym_low;
	logic [CFG_DATA_W-1:0] sym_high;
	logic [CNT_W-1:0]      sym_count;

	parse_phase_t          phase;
	logic                  negative;
	logic [VALUE_BITS-1:0] magnitude;

	result_t               expected_results[$];
	int                    fail_count = 0;
	int                    checked_count = 0;
	int                    rejected_count = 0;

	function automatic logic [CHAR_W-1:0] sym_at(input int i);
		if (i < 8) begin
			return sym_low[i*CHAR_W +: CHAR_W];
		end
		return sym_high[(i-8)*CHAR_W +: CHAR_W];
	endfunction

	function automatic bit blank_char(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit alphabet_good();
		int                n;
		int                i;
		int                j;
		logic [CHAR_W-1:0] s;
		n = sym_count;
		if (n < 2 || n > MAX_SYMBOLS || n > SYM_SLOTS) begin
			return 1'b0;
		end
		for (i = 0; i < n; i++) begin
			s = sym_at(i);
			if (s == CH_MINUS || s == CH_PLUS || blank_char(s)) begin
				return 1'b0;
			end
			for (j = i + 1; j < n; j++) begin
				if (sym_at(j) == s) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// Position of the first symbol in use that matches, or -1.
	function automatic int digit_value(input logic [CHAR_W-1:0] c);
		int n;
		int i;
		n = sym_count;
		if (n > MAX_SYMBOLS) begin
			n = MAX_SYMBOLS;
		end
		if (n > SYM_SLOTS) begin
			n = SYM_SLOTS;
		end
		if (c == CH_NUL) begin
			return -1;
		end
		for (i = 0; i < n; i++) begin
			if (sym_at(i) == c) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Advances the parse by one character; a zero byte queues a result.
	function automatic void consume_char(input logic [CHAR_W-1:0] c);
		result_t               r;
		logic [VALUE_BITS-1:0] v;
		int                    d;
		if (c == CH_NUL) begin
			r.ok = alphabet_good();
			r.value = '0;
			if (r.ok) begin
				v = negative ? -magnitude : magnitude;
				r.value = OUT_W'(v);
			end
			expected_results.push_back(r);
			phase = PHASE_SKIP;
			negative = 1'b0;
			magnitude = '0;
			return;
		end
		if (phase == PHASE_SKIP) begin
			if (blank_char(c)) begin
				return;
			end
			phase = PHASE_SIGN;
		end
		if (phase == PHASE_SIGN) begin
			if (c == CH_MINUS) begin
				negative = !negative;
				return;
			end
			if (c == CH_PLUS) begin
				return;
			end
			phase = PHASE_DIGITS;
		end
		if (phase == PHASE_DIGITS) begin
			d = digit_value(c);
			if (d >= 0) begin
				magnitude = magnitude * VALUE_BITS'(sym_count) + VALUE_BITS'(d);
			end else begin
				phase = PHASE_DONE;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			sym_low = '0;
			sym_high = '0;
			sym_count = '0;
			phase = PHASE_SKIP;
			negative = 1'b0;
			magnitude = '0;
		end else begin
			// Results are compared before this edge's character is folded in, so a
			// result can never match an expectation queued at the same edge.
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: result %0d ok=%0b arrived with nothing expected",
						$time, parsed_value, alphabet_ok);
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (!want.ok) begin
						rejected_count++;
					end
					if (parsed_value !== want.value) begin
						fail_count++;
						$display("%0t: parsed_value expected %0d got %0d", $time,
							$signed(want.value), parsed_value);
					end
					if (alphabet_ok !== want.ok) begin
						fail_count++;
						$display("%0t: alphabet_ok expected %0b got %0b", $time,
							want.ok, alphabet_ok);
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SYMBOLS_LOW: begin
						sym_low = cfg_data;
					end
					CFG_SYMBOLS_HIGH: begin
						sym_high = cfg_data;
					end
					CFG_SYMBOL_COUNT: begin
						sym_count = cfg_data[CNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				consume_char(char_in);
			end
		end
		mismatches <= fail_count;
		pending <= expected_results.size();
		strings_checked <= checked_count;
		rejected_checked <= rejected_count;
	end

endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for the radix string to integer parser
// Streams strings through the parser under a series of digit alphabets,
// valid and broken, with random gaps on both sides; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import rsti_pkg::*; ;

	// Characters to send before the random part stops; every character is one
	// input request, and the last batch of strings runs a little past this.
	localparam int CHAR_TARGET = 700;
	// Cycles let pass around configuration writes and at the end. The parser
	// loads a result into its output register after the zero byte leaves the
	// input register, and registers its alphabet check after a write.
	localparam int SETTLE      = 4;
	// Cycles without any accepted request before the run is declared hung.
	localparam int IDLE_LIMIT  = 2000;

	typedef enum int {
		SPOIL_NONE,
		SPOIL_COUNT,
		SPOIL_DUP,
		SPOIL_PLUS,
		SPOIL_MINUS,
		SPOIL_BLANK
	} spoil_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_SYMBOLS_LOW;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	wire                     in_ready;
	logic [CHAR_W-1:0]       char_in = CH_NUL;
	wire                     out_valid;
	logic                    out_ready = 1'b0;
	wire  signed [OUT_W-1:0] parsed_value;
	wire                     alphabet_ok;

	int mismatches;
	int pending;
	int strings_checked;
	int rejected_checked;

	// The alphabet currently programmed, one byte per slot, and its size.
	logic [CHAR_W-1:0] alpha[SYM_SLOTS];
	int                alpha_n = 0;

	int chars_sent = 0;
	int alphabets_written = 0;
	int sender_quiet = 0;
	int receiver_quiet = 0;
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	radix_string_to_int_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_in      (char_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.parsed_value (parsed_value),
		.alphabet_ok  (alphabet_ok)
	);

	rsti_result_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.char_in          (char_in),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.parsed_value     (parsed_value),
		.alphabet_ok      (alphabet_ok),
		.mismatches       (mismatches),
		.pending          (pending),
		.strings_checked  (strings_checked),
		.rejected_checked (rejected_checked)
	);

	// Cycles to wait before the next request. Most draws are uniform over 0 to
	// 11, but now and then a stretch of back-to-back requests starts, so both
	// the gapped and the full-rate cases get exercised.
	function automatic int next_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(5, 40);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [CHAR_W-1:0] random_blank();
		if ($urandom_range(0, 5) == 0) begin
			return CH_SPACE;
		end
		return CHAR_W'(CH_TAB + $urandom_range(0, 4));
	endfunction

	// A nonzero symbol of the current alphabet. A zero byte would end the string,
	// so it is never drawn; alphabets too small to pick from give any nonzero byte.
	function automatic logic [CHAR_W-1:0] random_digit();
		logic [CHAR_W-1:0] c;
		if (alpha_n < 2) begin
			return CHAR_W'($urandom_range(1, 255));
		end
		do begin
			c = alpha[$urandom_range(0, alpha_n - 1)];
		end while (c == CH_NUL);
		return c;
	endfunction

	// Sends one character request. Valid is dropped only for a real gap, and
	// once raised it stays up with the same character until accepted.
	task automatic send_char(input logic [CHAR_W-1:0] c);
		int gap;
		gap = next_wait(sender_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (!in_ready);
		chars_sent++;
	endtask

	// Sends the text followed by its zero byte.
	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
		send_char(CH_NUL);
	endtask

	// Most strings follow the shape the parser expects: blanks, signs, digits of
	// the current alphabet, sometimes trailing junk. The rest are random bytes.
	// Long digit runs push the accumulator well past 32 bits.
	task automatic send_random_string();
		logic [CHAR_W-1:0] body[$];
		int                n;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(0, 10)) body.push_back(CHAR_W'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) body.push_back(random_blank());
			repeat ($urandom_range(0, 3)) body.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			repeat (n) body.push_back(random_digit());
			if ($urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(1, 4)) body.push_back(CHAR_W'($urandom_range(1, 255)));
			end
		end
		foreach (body[i]) begin
			send_char(body[i]);
		end
		send_char(CH_NUL);
	endtask

	task automatic use_text_alphabet(input string s);
		int k;
		for (k = 0; k < SYM_SLOTS; k++) begin
			alpha[k] = (k < s.len()) ? s[k] : CH_NUL;
		end
		alpha_n = s.len();
	endtask

	// Builds an alphabet of n distinct symbols that are neither signs nor
	// blanks, then breaks it in the way the spoil kind asks. Slots past n get
	// random bytes, since the parser must ignore them.
	task automatic choose_alphabet(input int n, input spoil_t spoil, input bit zero_sym);
		logic [CHAR_W-1:0] c;
		bit                dup;
		int                i;
		int                j;
		int                k;
		for (i = 0; i < SYM_SLOTS; i++) begin
			if (i < n) begin
				do begin
					c = CHAR_W'($urandom_range(1, 255));
					dup = 1'b0;
					for (j = 0; j < i; j++) begin
						if (alpha[j] == c) begin
							dup = 1'b1;
						end
					end
				end while (dup || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
					(c >= CH_TAB && c <= CH_CR));
			end else begin
				c = CHAR_W'($urandom_range(0, 255));
			end
			alpha[i] = c;
		end
		// A zero-byte symbol keeps the alphabet valid but can never be matched.
		if (zero_sym) begin
			alpha[$urandom_range(0, n - 1)] = CH_NUL;
		end
		case (spoil)
			SPOIL_DUP: begin
				j = $urandom_range(0, n - 1);
				do k = $urandom_range(0, n - 1); while (k == j);
				alpha[k] = alpha[j];
			end
			SPOIL_PLUS: begin
				alpha[$urandom_range(0, n - 1)] = CH_PLUS;
			end
			SPOIL_MINUS: begin
				alpha[$urandom_range(0, n - 1)] = CH_MINUS;
			end
			SPOIL_BLANK: begin
				alpha[$urandom_range(0, n - 1)] = random_blank();
			end
			default: begin
			end
		endcase
		alpha_n = n;
	endtask

	// Writes the current alphabet. The sender first holds back until the
	// parser has finished its last string and every expected result request
	// has been taken, and again after the writes so the alphabet check settles.
	task automatic program_alphabet();
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		int                    k;
		for (k = 0; k < 8; k++) begin
			lo[k*CHAR_W +: CHAR_W] = alpha[k];
			hi[k*CHAR_W +: CHAR_W] = alpha[k+8];
		end
		in_valid <= 1'b0;
		repeat (SETTLE) @(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_SYMBOLS_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= CFG_SYMBOLS_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= CFG_SYMBOL_COUNT;
		cfg_data <= CFG_DATA_W'(alpha_n);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		repeat (SETTLE) @(posedge clk);
		alphabets_written++;
	endtask

	// Result side: every result request waits a drawn number of cycles once it
	// shows up; a draw of zero leaves ready high so results leave at once.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = next_wait(receiver_quiet);
			if (stall == 0) begin
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
			end else begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				repeat (stall - 1) @(posedge clk);
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
			end
		end
	end

	// Watchdog: any accepted request on either side restarts the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int     k;
		int     n;
		spoil_t spoil;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the symbol count is zero, so both of these
		// strings must come back rejected with a zero value; the first one is
		// also the empty string.
		send_char(CH_NUL);
		send_text("7");

		// Plain decimal: the empty string, every blank code before a sign run
		// that cancels out, digits cut short by a non-digit, a minus followed
		// by the all-ones byte, and a value that overflows 32 bits.
		use_text_alphabet("0123456789");
		program_alphabet();
		send_char(CH_NUL);
		for (k = 0; k < 5; k++) begin
			send_char(CHAR_W'(CH_TAB + k));
		end
		send_char(CH_SPACE);
		send_text("-+-12x3");
		send_char(CH_MINUS);
		send_char(8'hFF);
		send_char(CH_NUL);
		send_text("9999999999");

		// Rejected alphabets: count zero with both words all ones, count one,
		// then a repeated symbol, a plus, a minus and a blank symbol.
		for (k = 0; k < SYM_SLOTS; k++) begin
			alpha[k] = 8'hFF;
		end
		alpha_n = 0;
		program_alphabet();
		repeat (2) send_random_string();
		choose_alphabet(1, SPOIL_COUNT, 1'b0);
		program_alphabet();
		repeat (2) send_random_string();
		for (k = SPOIL_DUP; k <= SPOIL_BLANK; k++) begin
			choose_alphabet($urandom_range(2, SYM_SLOTS), spoil_t'(k), 1'b0);
			program_alphabet();
			repeat (3) send_random_string();
		end

		// Valid corner alphabets: one holding a zero-byte symbol, the smallest
		// radix with an empty high word, and a full sixteen symbols.
		choose_alphabet($urandom_range(2, SYM_SLOTS), SPOIL_NONE, 1'b1);
		program_alphabet();
		repeat (4) send_random_string();
		use_text_alphabet("01");
		program_alphabet();
		repeat (6) send_random_string();
		choose_alphabet(SYM_SLOTS, SPOIL_NONE, 1'b0);
		program_alphabet();
		repeat (6) send_random_string();

		// Random part: a fresh alphabet every few strings, about one in six of
		// them broken on purpose.
		while (chars_sent < CHAR_TARGET) begin
			n = $urandom_range(2, SYM_SLOTS);
			spoil = SPOIL_NONE;
			if ($urandom_range(0, 5) == 0) begin
				spoil = spoil_t'($urandom_range(SPOIL_COUNT, SPOIL_BLANK));
			end
			if (spoil == SPOIL_COUNT) begin
				n = $urandom_range(0, 1);
			end
			choose_alphabet(n, spoil, spoil == SPOIL_NONE && $urandom_range(0, 7) == 0);
			program_alphabet();
			repeat ($urandom_range(6, 12)) send_random_string();
		end

		// Drain: let the last zero byte work through, then collect every result.
		in_valid <= 1'b0;
		repeat (SETTLE) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("tb_top: %0d characters sent under %0d alphabet settings", chars_sent,
			alphabets_written);
		$display("tb_top: %0d results compared, %0d of them from rejected alphabets",
			strings_checked, rejected_checked);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

[radix_string_to_int_top.f]
rtl/core/rsti_pkg.sv
rtl/core/rsti_alphabet.sv
rtl/core/radix_string_to_int_top.sv
sim/rsti_result_checker.sv
sim/tb_top.sv
